FILE: rtl/vgwo_pkg.sv
// shared types and constants for the visited grid wall outline block
package vgwo_pkg;

  localparam int IDX_W  = 8;
  localparam int BITS_W = 34;
  localparam int WIN_W  = BITS_W + 2;

  localparam logic [1:0] REQ_VISIT = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [1:0] ROW_PREV = 2'd0;
  localparam logic [1:0] ROW_CUR  = 2'd1;
  localparam logic [1:0] ROW_NEXT = 2'd2;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_prev;
    logic       cap_cur;
    logic       upd;
    logic       clr;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/vgwo_ctrl.sv
// request sequencer for the visited grid wall outline block
module vgwo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       req_type,
  output logic             req_stall,
  input  vgwo_pkg::sts_t   sts,
  output vgwo_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_VRD  = 8'b0000_0010,
    S_VUPD = 8'b0000_0100,
    S_RD0  = 8'b0000_1000,
    S_RD1  = 8'b0001_0000,
    S_RD2  = 8'b0010_0000,
    S_CLR  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.rd_sel   = vgwo_pkg::ROW_CUR;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch = 1'b1;
          case (req_type)
            vgwo_pkg::REQ_VISIT: state_next = S_VRD;
            vgwo_pkg::REQ_READ:  state_next = S_RD0;
            vgwo_pkg::REQ_CLEAR: state_next = S_CLR;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_VRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = vgwo_pkg::ROW_CUR;
        state_next = S_VUPD;
      end
      S_VUPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = vgwo_pkg::ROW_PREV;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.cap_prev = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = vgwo_pkg::ROW_CUR;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.cap_cur = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = vgwo_pkg::ROW_NEXT;
        state_next  = S_DONE;
      end
      S_CLR: begin
        cmd.clr    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/vgwo_dp.sv
// row memory, bounding box and outline datapath
module vgwo_dp #(
  parameter int GRID_SIDE = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  vgwo_pkg::cmd_t                      cmd,
  output vgwo_pkg::sts_t                      sts,
  input  logic [1:0]                          req_type,
  input  logic signed [4:0]                   x_coord,
  input  logic signed [4:0]                   y_coord,
  input  logic [5:0]                          line_index,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                was_visited,
  output logic                                out_of_range,
  output logic                                map_empty,
  output logic                                line_valid,
  output logic [5:0]                          line_count,
  output logic [5:0]                          column_count,
  output logic [vgwo_pkg::BITS_W-1:0]         visited_bits,
  output logic [vgwo_pkg::BITS_W-1:0]         wall_bits
);

  localparam int AW   = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int HALF = GRID_SIDE / 2;
  localparam int PW   = GRID_SIDE + vgwo_pkg::WIN_W + 2;
  localparam int IW   = vgwo_pkg::IDX_W;
  localparam int BW   = vgwo_pkg::BITS_W;
  localparam int WW   = vgwo_pkg::WIN_W;

  localparam logic signed [IW-1:0] HALF_S = IW'(HALF);
  localparam logic signed [IW-1:0] SIDE_S = IW'(GRID_SIDE);

  function automatic logic in_grid(input logic signed [IW-1:0] v);
    in_grid = !v[IW-1] && (v < SIDE_S);
  endfunction

  // latched request
  logic [1:0]        req;
  logic signed [4:0] x_q, y_q;
  logic [5:0]        idx_q;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req   <= req_type;
      x_q   <= x_coord;
      y_q   <= y_coord;
      idx_q <= line_index;
    end
  end

  // bounding box
  logic signed [4:0] min_x, max_x, min_y, max_y;
  logic              any_visited;

  logic signed [IW-1:0] xv, yv, min_x_e, min_y_e, lx, addr_s;
  logic [AW-1:0]        xa, ya, rd_addr, base;
  logic                 vis_ok;

  assign xv      = {{(IW-5){x_q[4]}}, x_q} + HALF_S;
  assign yv      = {{(IW-5){y_q[4]}}, y_q} + HALF_S;
  assign min_x_e = {{(IW-5){min_x[4]}}, min_x};
  assign min_y_e = {{(IW-5){min_y[4]}}, min_y};
  assign lx      = min_x_e - IW'(1) + {{(IW-6){1'b0}}, idx_q} + HALF_S;
  assign xa      = xv[AW-1:0];
  assign ya      = yv[AW-1:0];
  assign vis_ok  = in_grid(xv) && in_grid(yv);
  assign base    = AW'(min_y_e + HALF_S);

  always_comb begin
    case (cmd.rd_sel)
      vgwo_pkg::ROW_PREV: addr_s = lx - IW'(1);
      vgwo_pkg::ROW_NEXT: addr_s = lx + IW'(1);
      vgwo_pkg::ROW_CUR:  addr_s = (req == vgwo_pkg::REQ_VISIT) ? xv : lx;
      default:            addr_s = lx;
    endcase
  end
  assign rd_addr = addr_s[AW-1:0];

  // row memory with per-row valid bits
  logic [GRID_SIDE-1:0] mem [GRID_SIDE];
  logic [GRID_SIDE-1:0] row_valid;
  logic [GRID_SIDE-1:0] q_row, row_data, set_bit;
  logic                 q_ok, hit, wr;

  assign row_data = q_ok ? q_row : '0;
  assign hit      = row_data[ya];
  assign wr       = cmd.upd && vis_ok && !hit;
  assign set_bit  = {{(GRID_SIDE-1){1'b0}}, 1'b1} << ya;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      q_row <= mem[rd_addr];
    end
    if (wr) begin
      mem[xa] <= row_data | set_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      row_valid <= '0;
      q_ok      <= 1'b0;
    end else begin
      if (wr) begin
        row_valid[xa] <= 1'b1;
      end
      if (cmd.rd_en) begin
        q_ok <= in_grid(addr_s) && row_valid[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      min_x       <= '0;
      max_x       <= '0;
      min_y       <= '0;
      max_y       <= '0;
      any_visited <= 1'b0;
    end else if (wr) begin
      any_visited <= 1'b1;
      if (!any_visited) begin
        min_x <= x_q;
        max_x <= x_q;
        min_y <= y_q;
        max_y <= y_q;
      end else begin
        if (x_q < min_x) min_x <= x_q;
        if (x_q > max_x) max_x <= x_q;
        if (y_q < min_y) min_y <= y_q;
        if (y_q > max_y) max_y <= y_q;
      end
    end
  end

  // captured neighbor rows
  logic [GRID_SIDE-1:0] r_prev, r_cur;

  always_ff @(posedge clk) begin
    if (cmd.cap_prev) begin
      r_prev <= row_data;
    end
    if (cmd.cap_cur) begin
      r_cur <= row_data;
    end
  end

  // column windows, bit k is y = min_y - 2 + k
  logic [PW-1:0]    p0, p1, p2;
  logic [WW-1:0]    w0, w1, w2;
  logic [BW-1:0]    nbr, mask, vis_line, wall_line;
  logic [BW:0]      mask_w;
  logic signed [6:0] lines_w, cols_w;
  logic [5:0]       lines, cols;
  logic             idx_ok;

  assign p0 = {{WW{1'b0}}, r_prev, 2'b00};
  assign p1 = {{WW{1'b0}}, r_cur, 2'b00};
  assign p2 = {{WW{1'b0}}, row_data, 2'b00};
  assign w0 = WW'(p0 >> base);
  assign w1 = WW'(p1 >> base);
  assign w2 = WW'(p2 >> base);

  always_comb begin
    for (int j = 0; j < BW; j++) begin
      nbr[j] = w0[j] | w0[j+1] | w0[j+2] | w1[j] | w1[j+2] | w2[j] | w2[j+1] | w2[j+2];
    end
  end

  assign lines_w   = {{2{max_x[4]}}, max_x} - {{2{min_x[4]}}, min_x} + 7'sd3;
  assign cols_w    = {{2{max_y[4]}}, max_y} - {{2{min_y[4]}}, min_y} + 7'sd3;
  assign lines     = lines_w[5:0];
  assign cols      = cols_w[5:0];
  assign idx_ok    = idx_q < lines;
  assign mask_w    = ((BW+1)'(1) << cols) - (BW+1)'(1);
  assign mask      = mask_w[BW-1:0];
  assign vis_line  = w1[BW:1] & mask;
  assign wall_line = ~w1[BW:1] & nbr & mask;

  // result register
  logic load_ok, rd_ok, line_ok;
  assign sts.out_free = !(rsp_valid && rsp_stall);
  assign load_ok      = cmd.load;
  assign rd_ok        = (req == vgwo_pkg::REQ_READ) && any_visited;
  assign line_ok      = rd_ok && idx_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_ok) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      was_visited  <= (req == vgwo_pkg::REQ_VISIT) && vis_ok && hit;
      out_of_range <= (req == vgwo_pkg::REQ_VISIT) && !vis_ok;
      map_empty    <= (req == vgwo_pkg::REQ_READ) && !any_visited;
      line_valid   <= line_ok;
      line_count   <= rd_ok ? lines : '0;
      column_count <= rd_ok ? cols : '0;
      visited_bits <= line_ok ? vis_line : '0;
      wall_bits    <= line_ok ? wall_line : '0;
    end
  end

endmodule

FILE: rtl/visited_grid_wall_outline.sv
// top level of the visited grid wall outline block
//
//   beat      handshake             payload
//   request   req_valid/req_stall   req_type x_coord y_coord line_index
//   response  rsp_valid/rsp_stall   was_visited out_of_range map_empty line_valid
//                                   line_count column_count visited_bits wall_bits
//
// one request at a time; the row memory has a single read port
// visit reads the row then updates it, read does three row reads, clear empties the map, unknown type only responds
// a finished response sits in the output register while the next request is taken
// a stalled response holds the sequencer in its last state until the beat leaves
// reset clears the row valid bits and bounding box at once, no sweep
module visited_grid_wall_outline #(
  parameter int GRID_SIDE = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic signed [4:0]           x_coord,
  input  logic signed [4:0]           y_coord,
  input  logic [5:0]                  line_index,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        was_visited,
  output logic                        out_of_range,
  output logic                        map_empty,
  output logic                        line_valid,
  output logic [5:0]                  line_count,
  output logic [5:0]                  column_count,
  output logic [vgwo_pkg::BITS_W-1:0] visited_bits,
  output logic [vgwo_pkg::BITS_W-1:0] wall_bits
);

  vgwo_pkg::cmd_t cmd;
  vgwo_pkg::sts_t sts;

  vgwo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vgwo_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .line_index   (line_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .was_visited  (was_visited),
    .out_of_range (out_of_range),
    .map_empty    (map_empty),
    .line_valid   (line_valid),
    .line_count   (line_count),
    .column_count (column_count),
    .visited_bits (visited_bits),
    .wall_bits    (wall_bits)
  );

endmodule
